/* hdl/mphl_pkg.sv */
// shared types, codes and helpers of the multi-pattern match highlighter
`default_nettype none
package mphl_pkg;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TEXT = 2'd1,
    OP_END  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_EMIT,
    S_SUM
  } state_t;

  localparam int unsigned REG_PATTERN_COUNT = 0;

  // ascii upper-case fold
  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7a) begin
      return c - 8'd32;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hdl/mphl_cell.sv */
// one window cell: holds a byte, shifts toward the head, compares against a pattern byte
`default_nettype none
module mphl_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned LW  = 5
) (
  input  wire logic          clk,
  input  wire logic          clr,
  input  wire logic          shift,
  input  wire logic          ld,
  input  wire logic [7:0]    nb_in,
  input  wire logic [7:0]    ld_byte,
  input  wire logic [7:0]    cmp_byte,
  input  wire logic [LW-1:0] cmp_len,
  output logic [7:0]         q,
  output logic               eq
);

  logic [7:0] q_r;

  always_ff @(posedge clk) begin
    if (clr) begin
      q_r <= 8'd0;
    end else if (ld) begin
      q_r <= ld_byte;
    end else if (shift) begin
      q_r <= nb_in;
    end
  end

  assign q  = q_r;
  // positions past the pattern length always agree
  assign eq = (32'(cmp_len) <= IDX) ||
              (mphl_pkg::fold(q_r) == mphl_pkg::fold(cmp_byte));

endmodule
`default_nettype wire

/* hdl/multi_pattern_match_highlighter.sv */
// top level of the multi-pattern match highlighter
//
// Patterns are loaded one byte per item (no result). Text bytes enter a
// lookahead window built as a chain of cells; while the window is not full a
// text item is only stored in it. Once it is full, each text item decides the
// oldest byte: the patterns are read from the pattern memory one row per
// cycle and compared in all cells at once, through the single read port of
// the pattern memory and the registered compare stage behind it. End of text
// emits every window byte that way, and then a summary item with the
// saturating match count and the number of distinct patterns seen. A result
// waits in an output register; the input is stalled from the start of an
// item's evaluation until its result has been taken into the output register.
`default_nettype none
module multi_pattern_match_highlighter #(
  parameter int unsigned MAX_PATTERNS    = 8,
  parameter int unsigned MAX_PATTERN_LEN = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [2:0]  in_slot,
  input  wire logic [3:0]  in_position,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_pattern_end,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_text_byte,
  output logic             out_highlighted,
  output logic             out_match_begins,
  output logic             out_is_summary,
  output logic [15:0]      out_total_matches,
  output logic [3:0]       out_distinct_found,
  output logic             out_last,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned LEN = MAX_PATTERN_LEN;
  localparam int unsigned AW  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned PW  = $clog2(MAX_PATTERNS + 1);
  localparam int unsigned LAW = (LEN > 1) ? $clog2(LEN) : 1;
  localparam int unsigned LW  = $clog2(LEN + 1);

  // configuration register
  logic [3:0] pcount_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (32'(cfg_paddr[2]) == mphl_pkg::REG_PATTERN_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r <= 4'd0;
    end else if (cfg_wr) begin
      pcount_r <= cfg_pwdata[3:0];
    end
  end

  assign cfg_prdata = (32'(cfg_paddr[2]) == mphl_pkg::REG_PATTERN_COUNT) ?
                      {28'd0, pcount_r} : 32'd0;

  // patterns in use, clipped to the storage
  logic [PW-1:0] n_pat;
  assign n_pat = (32'(pcount_r) > MAX_PATTERNS) ? PW'(MAX_PATTERNS) : PW'(pcount_r);

  mphl_pkg::state_t state_r, state_nxt;

  logic accept;
  logic out_free;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // load decode, out-of-range slots and positions are dropped
  logic          load_ok;
  logic [AW+2:0] slot_x;
  logic [LAW+3:0] pos_x;
  assign slot_x  = (AW + 3)'(in_slot);
  assign pos_x   = (LAW + 4)'(in_position);
  assign load_ok = accept && (mphl_pkg::op_t'(in_operation) == mphl_pkg::OP_LOAD) &&
                   (32'(in_slot) < MAX_PATTERNS) && (32'(in_position) < LEN);

  // pattern memory, one row per pattern, and the length table
  logic [LEN-1:0][7:0] pmem [MAX_PATTERNS];
  logic [LW-1:0]       plen_r [MAX_PATTERNS];

  // evaluation sequencer
  logic [PW-1:0]       cnt_r, cnt_nxt;
  logic                issue;
  logic [LEN-1:0][7:0] rrow_r;
  logic [LW-1:0]       rlen_r;
  logic [AW-1:0]       pidx_r;
  logic                vld_r;

  assign issue = (state_r == mphl_pkg::S_EVAL) && (cnt_r < n_pat);

  always_ff @(posedge clk) begin
    if (load_ok) begin
      pmem[slot_x[AW-1:0]][pos_x[LAW-1:0]] <= in_byte_value;
    end
    if (issue) begin
      rrow_r <= pmem[cnt_r[AW-1:0]];
      rlen_r <= plen_r[cnt_r[AW-1:0]];
      pidx_r <= cnt_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PATTERNS; i++) begin
        plen_r[i] <= '0;
      end
    end else if (load_ok && in_pattern_end) begin
      plen_r[slot_x[AW-1:0]] <= LW'(pos_x[LAW-1:0]) + LW'(1);
    end
  end

  // window chain
  logic [LW-1:0]       fill_r, fill_nxt;
  logic [LEN-1:0][7:0] win_q;
  logic [LEN-1:0]      win_eq;
  logic                w_clr, w_shift, w_ld;
  logic [LAW-1:0]      w_ld_idx;
  logic [7:0]          w_ld_byte;
  logic [7:0]          pend_byte_r;
  logic                flush_r;

  for (genvar k = 0; k < LEN; k++) begin : g_cell
    logic [7:0] nb;
    if (k == LEN - 1) begin : g_tail
      assign nb = 8'd0;
    end else begin : g_mid
      assign nb = win_q[k+1];
    end
    mphl_cell #(.IDX(k), .LW(LW)) u_cell (
      .clk      (clk),
      .clr      (w_clr || !rst_n),
      .shift    (w_shift),
      .ld       (w_ld && (32'(w_ld_idx) == k)),
      .nb_in    (nb),
      .ld_byte  (w_ld_byte),
      .cmp_byte (rrow_r[k]),
      .cmp_len  (rlen_r),
      .q        (win_q[k]),
      .eq       (win_eq[k])
    );
  end

  // match of the pattern in the compare stage at the oldest position
  logic pmatch;
  assign pmatch = vld_r && (&win_eq) && (rlen_r != '0) && (rlen_r <= fill_r);

  logic                    hit_r;
  logic [LW-1:0]           hlen_r;
  logic [MAX_PATTERNS-1:0] found_r;
  logic [LW-1:0]           rem_r;
  logic [15:0]             total_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mphl_pkg::S_IDLE: begin
        if (accept) begin
          if (mphl_pkg::op_t'(in_operation) == mphl_pkg::OP_TEXT) begin
            if (32'(fill_r) >= LEN) begin
              state_nxt = mphl_pkg::S_EVAL;
            end
          end else if (mphl_pkg::op_t'(in_operation) == mphl_pkg::OP_END) begin
            state_nxt = (fill_r != '0) ? mphl_pkg::S_EVAL : mphl_pkg::S_SUM;
          end
        end
      end
      mphl_pkg::S_EVAL: begin
        if (!issue && !vld_r) begin
          state_nxt = mphl_pkg::S_EMIT;
        end
      end
      mphl_pkg::S_EMIT: begin
        if (out_free) begin
          if (!flush_r) begin
            state_nxt = mphl_pkg::S_IDLE;
          end else if (fill_r > LW'(1)) begin
            state_nxt = mphl_pkg::S_EVAL;
          end else begin
            state_nxt = mphl_pkg::S_SUM;
          end
        end
      end
      mphl_pkg::S_SUM: begin
        if (out_free) begin
          state_nxt = mphl_pkg::S_IDLE;
        end
      end
      default: state_nxt = mphl_pkg::S_IDLE;
    endcase
  end

  // control outputs of the sequencer
  logic emit_go, sum_go;
  always_comb begin
    in_stall  = 1'b1;
    w_clr     = 1'b0;
    w_shift   = 1'b0;
    w_ld      = 1'b0;
    w_ld_idx  = fill_r[LAW-1:0];
    w_ld_byte = in_byte_value;
    emit_go   = 1'b0;
    sum_go    = 1'b0;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      mphl_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cnt_nxt  = '0;
        if (accept && (mphl_pkg::op_t'(in_operation) == mphl_pkg::OP_TEXT) &&
            (32'(fill_r) < LEN)) begin
          w_ld     = 1'b1;
          fill_nxt = fill_r + LW'(1);
        end
      end
      mphl_pkg::S_EVAL: begin
        if (issue) begin
          cnt_nxt = cnt_r + PW'(1);
        end
      end
      mphl_pkg::S_EMIT: begin
        cnt_nxt = '0;
        if (out_free) begin
          emit_go   = 1'b1;
          w_shift   = 1'b1;
          w_ld      = !flush_r;
          w_ld_idx  = LAW'(fill_r - LW'(1));
          w_ld_byte = pend_byte_r;
          fill_nxt  = flush_r ? fill_r - LW'(1) : fill_r;
        end
      end
      mphl_pkg::S_SUM: begin
        if (out_free) begin
          sum_go   = 1'b1;
          w_clr    = 1'b1;
          fill_nxt = '0;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // distinct pattern count
  logic [PW-1:0] distinct;
  always_comb begin
    distinct = '0;
    for (int p = 0; p < MAX_PATTERNS; p++) begin
      distinct = distinct + PW'(found_r[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mphl_pkg::S_IDLE;
      fill_r  <= '0;
      cnt_r   <= '0;
      vld_r   <= 1'b0;
      hit_r   <= 1'b0;
      found_r <= '0;
      rem_r   <= '0;
      total_r <= 16'd0;
      flush_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= issue;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        flush_r <= (mphl_pkg::op_t'(in_operation) == mphl_pkg::OP_END);
      end
      if (pmatch) begin
        found_r[pidx_r] <= 1'b1;
        if (!hit_r) begin
          hit_r <= 1'b1;
        end
      end
      if (emit_go) begin
        out_valid <= 1'b1;
        hit_r     <= 1'b0;
        if (rem_r != '0) begin
          rem_r <= rem_r - LW'(1);
        end else if (hit_r) begin
          rem_r <= hlen_r - LW'(1);
          if (total_r != 16'hffff) begin
            total_r <= total_r + 16'd1;
          end
        end
      end
      if (sum_go) begin
        out_valid <= 1'b1;
        rem_r     <= '0;
        total_r   <= 16'd0;
        found_r   <= '0;
        hit_r     <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && (mphl_pkg::op_t'(in_operation) == mphl_pkg::OP_TEXT)) begin
      pend_byte_r <= in_byte_value;
    end
    if (pmatch && !hit_r) begin
      hlen_r <= rlen_r;
    end
    if (emit_go) begin
      out_text_byte      <= win_q[0];
      out_highlighted    <= (rem_r != '0) || hit_r;
      out_match_begins   <= (rem_r == '0) && hit_r;
      out_is_summary     <= 1'b0;
      out_total_matches  <= 16'd0;
      out_distinct_found <= 4'd0;
      out_last           <= 1'b0;
    end
    if (sum_go) begin
      out_text_byte      <= 8'd0;
      out_highlighted    <= 1'b0;
      out_match_begins   <= 1'b0;
      out_is_summary     <= 1'b1;
      out_total_matches  <= total_r;
      out_distinct_found <= 4'(distinct);
      out_last           <= 1'b1;
    end
  end

endmodule
`default_nettype wire

/* hdl/mphl_checker.sv */
// port-level checker of the highlighter, bound to the top level
`default_nettype none
module mphl_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_text_byte,
  input wire logic        out_highlighted,
  input wire logic        out_match_begins,
  input wire logic        out_is_summary,
  input wire logic [15:0] out_total_matches,
  input wire logic        out_last
);

  a_begin_hl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_match_begins) |-> out_highlighted)
    else $error("match start without highlight");

  a_last_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_is_summary))
    else $error("last flag not on summary item");

  a_sum_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_summary) |-> (out_text_byte == 8'd0 && !out_highlighted))
    else $error("summary item carries byte data");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_total_matches) &&
                                  $stable(out_text_byte)))
    else $error("stalled result changed");

endmodule

bind multi_pattern_match_highlighter mphl_port_checker u_mphl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_text_byte     (out_text_byte),
  .out_highlighted   (out_highlighted),
  .out_match_begins  (out_match_begins),
  .out_is_summary    (out_is_summary),
  .out_total_matches (out_total_matches),
  .out_last          (out_last)
);
`default_nettype wire

/* dv/mphl_checker.sv */
// result checker with a match predictor for the multi-pattern match highlighter
`default_nettype none
module mphl_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [2:0]  in_slot,
  input  wire logic [3:0]  in_position,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_pattern_end,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  out_text_byte,
  input  wire logic        out_highlighted,
  input  wire logic        out_match_begins,
  input  wire logic        out_is_summary,
  input  wire logic [15:0] out_total_matches,
  input  wire logic [3:0]  out_distinct_found,
  input  wire logic        out_last,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               fail_count,
  output int               pending_count,
  output int               byte_results,
  output int               summaries
);

  typedef struct packed {
    logic [7:0]  text_byte;
    logic        highlighted;
    logic        match_begins;
    logic        is_summary;
    logic [15:0] total_matches;
    logic [3:0]  distinct_found;
    logic        last;
  } marked_t;

  marked_t     awaited_marks[$];
  logic [7:0]  pat_bytes[8][16];
  logic [4:0]  pat_len[8];
  logic [7:0]  win[16];
  int          win_fill;
  int          cover_left;
  logic [15:0] hits;
  logic [7:0]  seen;
  logic [3:0]  active_pats;

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
  endfunction

  function automatic bit pattern_at_head(int p);
    if (pat_len[p] == 0 || pat_len[p] > win_fill) return 0;
    for (int k = 0; k < pat_len[p]; k++)
      if (upcase(win[k]) != upcase(pat_bytes[p][k])) return 0;
    return 1;
  endfunction

  function automatic void release_head();
    int n;
    marked_t m;
    n = active_pats > 8 ? 8 : active_pats;
    m = '0;
    for (int p = 0; p < n; p++)
      if (pattern_at_head(p)) seen[p] = 1'b1;
    if (cover_left > 0) begin
      m.highlighted = 1;
      cover_left--;
    end else begin
      for (int p = 0; p < n; p++) begin
        if (pattern_at_head(p)) begin
          m.highlighted = 1;
          m.match_begins = 1;
          cover_left = pat_len[p] - 1;
          if (hits != 16'hffff) hits++;
          break;
        end
      end
    end
    m.text_byte = win[0];
    for (int k = 0; k < 15; k++) win[k] = win[k+1];
    win[15] = 8'd0;
    win_fill--;
    awaited_marks.push_back(m);
  endfunction

  marked_t got;
  marked_t want;
  marked_t sum_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_marks.delete();
      foreach (pat_len[p]) pat_len[p] = 0;
      foreach (win[k]) win[k] = 0;
      foreach (pat_bytes[p, k]) pat_bytes[p][k] = 0;
      win_fill = 0; cover_left = 0; hits = 0; seen = 0; active_pats = 0;
      fail_count <= 0; byte_results <= 0; summaries <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == 3'(4 * mphl_pkg::REG_PATTERN_COUNT))
        active_pats = cfg_pwdata[3:0];
      if (out_valid && !out_stall) begin
        got = {out_text_byte, out_highlighted, out_match_begins, out_is_summary,
               out_total_matches, out_distinct_found, out_last};
        if (got.is_summary) summaries <= summaries + 1;
        else byte_results <= byte_results + 1;
        if (awaited_marks.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_marks.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("mismatch: expected byte %h hl %b mb %b sum %b tot %0d dist %0d last %b",
                want.text_byte, want.highlighted, want.match_begins, want.is_summary,
                want.total_matches, want.distinct_found, want.last);
              $display("          got      byte %h hl %b mb %b sum %b tot %0d dist %0d last %b",
                got.text_byte, got.highlighted, got.match_begins, got.is_summary,
                got.total_matches, got.distinct_found, got.last);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (mphl_pkg::op_t'(in_operation))
          mphl_pkg::OP_LOAD: begin
            pat_bytes[in_slot][in_position] = in_byte_value;
            if (in_pattern_end) pat_len[in_slot] = 5'(in_position) + 5'd1;
          end
          mphl_pkg::OP_TEXT: begin
            if (win_fill >= 16) release_head();
            win[win_fill] = in_byte_value;
            win_fill++;
          end
          mphl_pkg::OP_END: begin
            while (win_fill > 0) release_head();
            sum_item = '0;
            sum_item.is_summary = 1;
            sum_item.total_matches = hits;
            sum_item.distinct_found = 4'($countones(seen));
            sum_item.last = 1;
            awaited_marks.push_back(sum_item);
            foreach (win[k]) win[k] = 0;
            win_fill = 0; cover_left = 0; hits = 0; seen = 0;
          end
          default: ;
        endcase
      end
    end
    pending_count <= awaited_marks.size();
  end

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// stimulus and verdict for the multi-pattern match highlighter testbench
`default_nettype none
module tb_top;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_operation = mphl_pkg::OP_NONE;
  logic [2:0]  in_slot = 0;
  logic [3:0]  in_position = 0;
  logic [7:0]  in_byte_value = 8'h41;
  logic        in_pattern_end = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  out_text_byte;
  logic        out_highlighted, out_match_begins, out_is_summary, out_last;
  logic [15:0] out_total_matches;
  logic [3:0]  out_distinct_found;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count, pending_count, byte_results, summaries;
  int send_idle_pct = 0;   // chance in percent that the sender skips a cycle
  int stall_pct = 0;       // chance in percent that the receiver stalls
  int hold_cycles = 0;     // long receiver hold-off, counted down by the stall process
  int items_sent = 0;

  // mirror of the loaded patterns, used to build matching text
  logic [7:0] pat_img[8][16];
  int         pat_sz[8];

  always #5 clk = ~clk;

  multi_pattern_match_highlighter i_dut (.*);

  mphl_checker i_checker (.*);

  // receiver: random stall, or a long hold-off while hold_cycles runs down
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // one input item; random idle cycles in front of it, valid held until taken
  task automatic send_item(mphl_pkg::op_t op, logic [2:0] sl, logic [3:0] pos,
                           logic [7:0] val, logic pend);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_slot <= sl;
    in_position <= pos;
    in_byte_value <= val;
    in_pattern_end <= pend;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (40) @(negedge clk);  // a failing or unmatched item may still be in flight
  endtask

  task automatic write_pattern_count(logic [3:0] n);
    in_valid <= 0;
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= 3'(4 * mphl_pkg::REG_PATTERN_COUNT); cfg_pwdata <= 32'(n);
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic load_pattern(int sl, int len, logic [7:0] bytes[16]);
    for (int k = 0; k < len; k++) begin
      pat_img[sl][k] = bytes[k];
      send_item(mphl_pkg::OP_LOAD, 3'(sl), 4'(k), bytes[k], k == len - 1);
    end
    pat_sz[sl] = len;
  endtask

  // random byte, mostly letters in either case so matches actually happen
  function automatic logic [7:0] rnd_byte();
    if ($urandom_range(3) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(0, 3)) + (($urandom_range(1)) ? 8'h41 : 8'h61);
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)) return c ^ 8'h20;
    return c;
  endfunction

  // a text run: mostly pattern copies with random case, plus noise
  task automatic send_text(int n);
    int s, k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(1) == 0) begin
        s = $urandom_range(7);
        if (pat_sz[s] > 0) begin
          for (int j = 0; j < pat_sz[s] && k < n; j++, k++)
            send_item(mphl_pkg::OP_TEXT, 3'($urandom), 4'($urandom),
                      $urandom_range(1) ? flip_case(pat_img[s][j]) : pat_img[s][j],
                      1'b0);
          continue;
        end
      end
      send_item(mphl_pkg::OP_TEXT, 3'($urandom), 4'($urandom), rnd_byte(),
                1'($urandom));
      k++;
    end
  endtask

  logic [7:0] pbuf[16];

  initial begin
    for (int s = 0; s < 8; s++) pat_sz[s] = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: zero patterns pass text unmarked, then a lone end of text
    send_text(3);
    send_item(mphl_pkg::OP_END, 3'd0, 4'd0, 8'h01, 1'b0);
    send_item(mphl_pkg::OP_END, 3'd0, 4'd0, 8'hff, 1'b1);
    // unknown operation is dropped
    send_item(mphl_pkg::OP_NONE, 3'h7, 4'hf, 8'hff, 1'b1);
    wait_drained();

    // overlapping priorities: slot 0 "AB", slot 1 "abc", slot 7 full length
    pbuf[0] = 8'h41; pbuf[1] = 8'h42;
    load_pattern(0, 2, pbuf);
    pbuf[0] = 8'h61; pbuf[1] = 8'h62; pbuf[2] = 8'h63;
    load_pattern(1, 3, pbuf);
    for (int k = 0; k < 16; k++) pbuf[k] = (k == 0) ? 8'hff : 8'h80 + 8'(k);
    load_pattern(7, 16, pbuf);
    write_pattern_count(4'd15);  // above the slot count acts as eight
    send_text(20);
    // pattern close to end of text never matches past the last byte
    send_item(mphl_pkg::OP_TEXT, 3'd0, 4'd0, 8'h61, 1'b0);
    send_item(mphl_pkg::OP_END, 3'd0, 4'd0, 8'h01, 1'b0);
    wait_drained();

    // random phases over several register settings and idle mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      // reload a couple of slots with fresh patterns, mostly short ones
      for (int r = 0; r < 2; r++) begin
        int sl, ln;
        sl = $urandom_range(7);
        ln = (ph == 5 && r == 0) ? 16 : $urandom_range(1, 4);
        for (int k = 0; k < 16; k++) pbuf[k] = rnd_byte();
        load_pattern(sl, ln, pbuf);
      end
      write_pattern_count(ph == 0 ? 4'd0 : ph == 7 ? 4'd8 : 4'($urandom_range(1, 8)));
      if (ph == 3) hold_cycles = 300;  // receiver holds off, window backs up
      send_text($urandom_range(20, 34));
      send_item(mphl_pkg::OP_END, 3'($urandom), 4'($urandom), rnd_byte(),
                1'($urandom));
      wait_drained();
    end
    stall_pct = 0;
    repeat (50) @(negedge clk);

    $display("covered %0d items: %0d byte results and %0d summaries checked",
             items_sent, byte_results, summaries);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
